// File: hdl/evpid_pkg.sv
// Package for the encoder velocity PID motor drive.
// Holds widths, constants, codes, state encoding and the divider bundle types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package evpid_pkg;

  // Field widths.
  localparam int unsigned TIME_BITS  = 32;
  localparam int unsigned DUTY_BITS  = 8;
  localparam int unsigned GAIN_BITS  = 16;
  localparam int unsigned RPM_BITS   = 10;
  localparam int unsigned CPR_BITS   = 16;
  localparam int unsigned SPEED_BITS = 9;
  localparam int unsigned POS_BITS   = 32;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 16;

  // PID datapath widths.
  localparam int unsigned ERR_BITS   = 11;
  localparam int unsigned DELTA_BITS = 12;
  localparam int unsigned SUM_BITS   = 8;
  localparam int unsigned PROD_BITS  = GAIN_BITS + DELTA_BITS;
  localparam int unsigned ACC_BITS   = PROD_BITS + 2;

  // Speed scaling: rpm = RPM_NUM / interval / counts_per_rev.
  localparam int unsigned NUM_BITS = 26;
  localparam logic [NUM_BITS-1:0] RPM_NUM = NUM_BITS'(60000000);
  localparam logic [SPEED_BITS-1:0] SPEED_MAX = SPEED_BITS'(500);
  localparam logic signed [DELTA_BITS-1:0] SUM_HI = DELTA_BITS'(100);
  localparam logic signed [DELTA_BITS-1:0] SUM_LO = -DELTA_BITS'(100);
  localparam int unsigned DIV_CNT_BITS = $clog2(NUM_BITS + 1);

  // Item operation codes.
  typedef enum logic [1:0] {
    OP_EDGE_A = 2'd0,
    OP_EDGE_B = 2'd1,
    OP_UPDATE = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_GAIN_P     = 3'd0,
    CFG_GAIN_I     = 3'd1,
    CFG_GAIN_D     = 3'd2,
    CFG_TARGET_RPM = 3'd3,
    CFG_DUTY_LIMIT = 3'd4,
    CFG_REVERSE    = 3'd5,
    CFG_CPR        = 3'd6
  } cfg_idx_e;

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_SETUP = 10'b00_0000_0010,
    ST_DIV1  = 10'b00_0000_0100,
    ST_DIV2  = 10'b00_0000_1000,
    ST_ERR   = 10'b00_0001_0000,
    ST_MAC_P = 10'b00_0010_0000,
    ST_MAC_I = 10'b00_0100_0000,
    ST_MAC_D = 10'b00_1000_0000,
    ST_DRIVE = 10'b01_0000_0000,
    ST_DONE  = 10'b10_0000_0000
  } state_e;

  // Divider request and response.
  typedef struct packed {
    logic                 start;
    logic [NUM_BITS-1:0]  dividend;
    logic [TIME_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [NUM_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: hdl/evpid_ifs.sv
// Channel interfaces for the encoder velocity PID motor drive.
// Item, result and configuration write channels; depends on evpid_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface evpid_in_if;
  import evpid_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [1:0]           operation;
  logic                 level_a;
  logic                 level_b;
  logic [TIME_BITS-1:0] time_us;
  modport source (output valid, operation, level_a, level_b, time_us, input ready);
  modport sink   (input valid, operation, level_a, level_b, time_us, output ready);
endinterface

interface evpid_out_if;
  import evpid_pkg::*;
  logic                         valid;
  logic                         ready;
  logic                         dir_a;
  logic                         dir_b;
  logic [DUTY_BITS-1:0]         pwm_duty;
  logic signed [POS_BITS-1:0]   position;
  logic [SPEED_BITS-1:0]        speed_rpm;
  modport source (output valid, dir_a, dir_b, pwm_duty, position, speed_rpm, input ready);
  modport sink   (input valid, dir_a, dir_b, pwm_duty, position, speed_rpm, output ready);
endinterface

interface evpid_cfg_if;
  import evpid_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/evpid_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Used twice per control update with a nonzero edge interval, for the speed scaling; depends on evpid_pkg.
`timescale 1ns / 1ps
`default_nettype none

module evpid_div (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  evpid_pkg::div_req_t req_i,
  output evpid_pkg::div_rsp_t rsp_o
);
  import evpid_pkg::*;

  logic [NUM_BITS-1:0]     quo_q, quo_d;
  logic [TIME_BITS-1:0]    rem_q, rem_d;
  logic [TIME_BITS-1:0]    dvs_q, dvs_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic                    done_q, done_d;
  logic [TIME_BITS:0]      trial;
  logic                    fits;

  // One restoring step: shift in the next dividend bit and try the subtract.
  always_comb begin
    trial  = {rem_q, quo_q[NUM_BITS-1]};
    fits   = trial >= {1'b0, dvs_q};
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      quo_d = req_i.dividend;
      rem_d = '0;
      dvs_d = req_i.divisor;
      cnt_d = DIV_CNT_BITS'(NUM_BITS);
    end else if (cnt_q != '0) begin
      rem_d  = fits ? TIME_BITS'(trial - {1'b0, dvs_q}) : trial[TIME_BITS-1:0];
      quo_d  = {quo_q[NUM_BITS-2:0], fits};
      cnt_d  = cnt_q - DIV_CNT_BITS'(1);
      done_d = (cnt_q == DIV_CNT_BITS'(1));
    end
  end

  // Step counter and completion flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

// File: hdl/encoder_velocity_pid_motor_drive.sv
// Top level of the encoder velocity PID motor drive.
// Depends on evpid_pkg, the channel interfaces and evpid_div.
//
// Usage:
//   cfg_i    : register writes (index, data); always ready, to be written while
//              the block is idle.
//   item_i   : one beat per encoder A edge, B edge, control update or no-op.
//   result_o : one beat per item with direction lines, duty, position, speed.
// Edge beats update the edge stamps, and A edges also the position count, in
// the accept cycle. Their result goes through the done state into the output
// register, and the next item can be taken once the sequencer is back in idle.
// A control update runs a sequencer around one shared restoring divider (two
// passes: numerator by edge interval, then by counts per revolution) and one
// shared 16x12 multiplier stepped through the three PID terms. Its steps are
// setup, the two divides, error, three multiply steps, drive and done; a zero
// edge interval skips the divider.
// item_i is ready only while the sequencer is idle, so one item is in work at
// a time. The result sits in an output register; the next item is accepted
// while it waits. If the receiver stalls, a finished item holds in its last
// step until the output register frees up.
// Reset clears the architectural state, gains and target to zero, the duty
// limit to 255 and counts per revolution to 1; the bridge lines coast.
`timescale 1ns / 1ps
`default_nettype none

module encoder_velocity_pid_motor_drive (
  input  wire            clk_i,
  input  wire            rst_ni,
  evpid_cfg_if.sink      cfg_i,
  evpid_in_if.sink       item_i,
  evpid_out_if.source    result_o
);
  import evpid_pkg::*;

  // Configuration registers.
  logic signed [GAIN_BITS-1:0] gain_p_q, gain_i_q, gain_d_q;
  logic [RPM_BITS-1:0]         target_q;
  logic [DUTY_BITS-1:0]        limit_q;
  logic                        reverse_q;
  logic [CPR_BITS-1:0]         cpr_q;

  // Block state.
  state_e                      state_q, state_d;
  logic [POS_BITS-1:0]         pos_q, pos_d;
  logic [TIME_BITS-1:0]        latest_q, latest_d, prev_q, prev_d;
  logic signed [ERR_BITS-1:0]  last_err_q, last_err_d;
  logic signed [SUM_BITS-1:0]  sum_q, sum_d;
  logic [SPEED_BITS-1:0]       speed_q, speed_d;
  logic [1:0]                  lines_q, lines_d;
  logic [DUTY_BITS-1:0]        duty_q, duty_d;

  // PID working registers.
  logic signed [ERR_BITS-1:0]   err_q, err_d;
  logic signed [DELTA_BITS-1:0] delta_q, delta_d;
  logic signed [ACC_BITS-1:0]   acc_q, acc_d;

  // Output register.
  logic                   out_valid_q, out_valid_d;
  logic [1:0]             out_lines_q;
  logic [DUTY_BITS-1:0]   out_duty_q;
  logic [POS_BITS-1:0]    out_pos_q;
  logic [SPEED_BITS-1:0]  out_speed_q;
  logic                   out_load;

  // Combinational helpers.
  logic                         in_fire;
  logic [TIME_BITS-1:0]         dt;
  logic [CPR_BITS-1:0]          cpr_eff;
  logic signed [ERR_BITS-1:0]   err_w;
  logic signed [DELTA_BITS-1:0] delta_w, sum_raw;
  logic signed [GAIN_BITS-1:0]  mul_a;
  logic signed [DELTA_BITS-1:0] mul_b;
  logic signed [PROD_BITS-1:0]  prod;
  logic [ACC_BITS-1:0]          mag;
  div_req_t                     div_req;
  div_rsp_t                     div_rsp;

  evpid_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_fire      = item_i.valid && item_i.ready;
  assign item_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready  = 1'b1;
  assign out_load     = (state_q == ST_DONE) && (!out_valid_q || result_o.ready);

  // Speed and error arithmetic.
  assign dt      = latest_q - prev_q;
  assign cpr_eff = (cpr_q == '0) ? CPR_BITS'(1) : cpr_q;
  assign err_w   = $signed({1'b0, target_q}) - $signed({2'b00, speed_q});
  assign delta_w = $signed({err_w[ERR_BITS-1], err_w})
                 - $signed({last_err_q[ERR_BITS-1], last_err_q});
  assign sum_raw = $signed({{(DELTA_BITS-SUM_BITS){sum_q[SUM_BITS-1]}}, sum_q})
                 + $signed({err_w[ERR_BITS-1], err_w});

  // Shared multiplier, operands picked by the sequencer step.
  always_comb begin
    unique case (state_q)
      ST_MAC_P: begin
        mul_a = gain_p_q;
        mul_b = $signed({err_q[ERR_BITS-1], err_q});
      end
      ST_MAC_I: begin
        mul_a = gain_i_q;
        mul_b = $signed({{(DELTA_BITS-SUM_BITS){sum_q[SUM_BITS-1]}}, sum_q});
      end
      default: begin
        mul_a = gain_d_q;
        mul_b = delta_q;
      end
    endcase
  end
  assign prod = mul_a * mul_b;
  assign mag  = acc_q[ACC_BITS-1] ? ACC_BITS'(-acc_q) : ACC_BITS'(acc_q);

  // Sequencer and state update.
  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    latest_d   = latest_q;
    prev_d     = prev_q;
    last_err_d = last_err_q;
    sum_d      = sum_q;
    speed_d    = speed_q;
    lines_d    = lines_q;
    duty_d     = duty_q;
    err_d      = err_q;
    delta_d    = delta_q;
    acc_d      = acc_q;
    div_req.start    = 1'b0;
    div_req.dividend = RPM_NUM;
    div_req.divisor  = dt;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (op_e'(item_i.operation))
            OP_EDGE_A: begin
              pos_d    = (item_i.level_a != item_i.level_b) ?
                         pos_q + POS_BITS'(1) : pos_q - POS_BITS'(1);
              prev_d   = latest_q;
              latest_d = item_i.time_us;
              state_d  = ST_DONE;
            end
            OP_EDGE_B: begin
              prev_d   = latest_q;
              latest_d = item_i.time_us;
              state_d  = ST_DONE;
            end
            OP_UPDATE: state_d = ST_SETUP;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_SETUP: begin
        // A zero interval reads as full speed without dividing.
        if (dt == '0) begin
          speed_d = SPEED_MAX;
          state_d = ST_ERR;
        end else begin
          div_req.start = 1'b1;
          state_d       = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = div_rsp.quotient;
          div_req.divisor  = {{(TIME_BITS-CPR_BITS){1'b0}}, cpr_eff};
          state_d          = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_rsp.done) begin
          speed_d = (div_rsp.quotient > NUM_BITS'(SPEED_MAX)) ?
                    SPEED_MAX : div_rsp.quotient[SPEED_BITS-1:0];
          state_d = ST_ERR;
        end
      end
      ST_ERR: begin
        // Error, change of error and the clamped error sum.
        err_d      = err_w;
        delta_d    = delta_w;
        last_err_d = err_w;
        if (sum_raw > SUM_HI) begin
          sum_d = SUM_BITS'(SUM_HI);
        end else if (sum_raw < SUM_LO) begin
          sum_d = SUM_BITS'(SUM_LO);
        end else begin
          sum_d = sum_raw[SUM_BITS-1:0];
        end
        acc_d   = '0;
        state_d = ST_MAC_P;
      end
      ST_MAC_P, ST_MAC_I, ST_MAC_D: begin
        acc_d = acc_q + $signed({{(ACC_BITS-PROD_BITS){prod[PROD_BITS-1]}}, prod});
        unique case (state_q)
          ST_MAC_P: state_d = ST_MAC_I;
          ST_MAC_I: state_d = ST_MAC_D;
          default:  state_d = ST_DRIVE;
        endcase
      end
      ST_DRIVE: begin
        // Sign picks the bridge direction, zero coasts.
        if (acc_q[ACC_BITS-1]) begin
          lines_d = reverse_q ? 2'b01 : 2'b10;
        end else if (acc_q != '0) begin
          lines_d = reverse_q ? 2'b10 : 2'b01;
        end else begin
          lines_d = 2'b00;
        end
        duty_d  = (mag > {{(ACC_BITS-DUTY_BITS){1'b0}}, limit_q}) ?
                  limit_q : mag[DUTY_BITS-1:0];
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register handshake.
  always_comb begin
    out_valid_d = out_valid_q;
    if (result_o.ready) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      latest_q    <= '0;
      prev_q      <= '0;
      last_err_q  <= '0;
      sum_q       <= '0;
      speed_q     <= '0;
      lines_q     <= '0;
      duty_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      latest_q    <= latest_d;
      prev_q      <= prev_d;
      last_err_q  <= last_err_d;
      sum_q       <= sum_d;
      speed_q     <= speed_d;
      lines_q     <= lines_d;
      duty_q      <= duty_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q  <= '0;
      gain_i_q  <= '0;
      gain_d_q  <= '0;
      target_q  <= '0;
      limit_q   <= '1;
      reverse_q <= 1'b0;
      cpr_q     <= CPR_BITS'(1);
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_GAIN_P:     gain_p_q  <= $signed(cfg_i.data[GAIN_BITS-1:0]);
        CFG_GAIN_I:     gain_i_q  <= $signed(cfg_i.data[GAIN_BITS-1:0]);
        CFG_GAIN_D:     gain_d_q  <= $signed(cfg_i.data[GAIN_BITS-1:0]);
        CFG_TARGET_RPM: target_q  <= cfg_i.data[RPM_BITS-1:0];
        CFG_DUTY_LIMIT: limit_q   <= cfg_i.data[DUTY_BITS-1:0];
        CFG_REVERSE:    reverse_q <= cfg_i.data[0];
        CFG_CPR:        cpr_q     <= cfg_i.data[CPR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // PID working registers and the output payload.
  always_ff @(posedge clk_i) begin
    err_q   <= err_d;
    delta_q <= delta_d;
    acc_q   <= acc_d;
    if (out_load) begin
      out_lines_q <= lines_q;
      out_duty_q  <= duty_q;
      out_pos_q   <= pos_q;
      out_speed_q <= speed_q;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.dir_a     = out_lines_q[0];
  assign result_o.dir_b     = out_lines_q[1];
  assign result_o.pwm_duty  = out_duty_q;
  assign result_o.position  = $signed(out_pos_q);
  assign result_o.speed_rpm = out_speed_q;

  // An accepted item always leaves the idle state on the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> state_q != ST_IDLE)
    else $error("accepted item did not start the sequencer");

  // The divider only finishes while the sequencer waits for it.
  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV1 || state_q == ST_DIV2))
    else $error("divider finished outside a divide step");

  // Speed and error sum stay within their clamps.
  a_clamps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    speed_q <= SPEED_MAX && sum_q <= SUM_BITS'(SUM_HI) && sum_q >= SUM_BITS'(SUM_LO))
    else $error("speed or error sum out of range");

  // The bridge never drives both lines high.
  a_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lines_q != 2'b11)
    else $error("both bridge lines driven");

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking testbench for the encoder velocity PID motor drive.
// Drives item and register beats, predicts each result beat and checks it field by field.
// Depends on evpid_pkg, the channel interfaces and the top level of the block.
`timescale 1ns / 1ps

module tb;
  import evpid_pkg::*;

  localparam int CLK_HIGH_NS     = 6;
  localparam int CLK_LOW_NS      = 6;
  localparam int RESET_CYCLES    = 7;
  localparam int CYCLE_LIMIT     = 1000000;
  localparam int N_REGS          = 7;
  localparam int PHASES          = 14;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int QUIET_PHASE     = 3;
  localparam int HOLD_PHASE      = 5;
  localparam int HOLD_CYCLES     = 800;
  localparam int IDLE_PCT        = 14;
  localparam int DRAIN_CYCLES    = 80;

  // One result beat as the block presents it.
  typedef struct packed {
    logic                       dir_a;
    logic                       dir_b;
    logic [DUTY_BITS-1:0]       duty;
    logic signed [POS_BITS-1:0] position;
    logic [SPEED_BITS-1:0]      speed;
  } drive_result_t;

  // One row of the directed stimulus: a register write or an item beat.
  typedef struct {
    logic                     is_reg;
    cfg_idx_e                 reg_idx;
    logic [CFG_DATA_BITS-1:0] reg_data;
    op_e                      op;
    logic                     lvl_a;
    logic                     lvl_b;
    logic [TIME_BITS-1:0]     stamp;
    logic                     has_typed;
    drive_result_t            typed;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  evpid_cfg_if cfg_bus ();
  evpid_in_if  item_bus ();
  evpid_out_if result_bus ();

  encoder_velocity_pid_motor_drive u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_bus),
    .item_i   (item_bus),
    .result_o (result_bus)
  );

  // Clock.
  always begin
    #CLK_HIGH_NS clk_i = 1'b1;
    #CLK_LOW_NS  clk_i = 1'b0;
  end

  // Predictor copy of the registers, at their reset values.
  logic signed [GAIN_BITS-1:0] kp = '0;
  logic signed [GAIN_BITS-1:0] ki = '0;
  logic signed [GAIN_BITS-1:0] kd = '0;
  logic [RPM_BITS-1:0]         rpm_goal = '0;
  logic [DUTY_BITS-1:0]        duty_cap = '1;
  logic                        swap_lines = 1'b0;
  logic [CPR_BITS-1:0]         counts_rev = CPR_BITS'(1);

  // Predictor copy of the block state.
  logic [POS_BITS-1:0]   pos_count = '0;
  logic [TIME_BITS-1:0]  stamp_latest = '0;
  logic [TIME_BITS-1:0]  stamp_prev = '0;
  int                    err_prev = 0;
  int                    err_acc = 0;
  logic [SPEED_BITS-1:0] speed_held = '0;
  logic [1:0]            lines_held = '0;
  logic [DUTY_BITS-1:0]  duty_held = '0;

  drive_result_t pending_results[$];
  stim_row_t     directed_rows[$];

  int            n_errors = 0;
  int            cycle_count = 0;
  logic          typed_on = 1'b0;
  drive_result_t typed_want;
  logic          sender_gaps = 1'b1;
  logic          receiver_stalls = 1'b1;
  logic          hold_req = 1'b0;
  int            hold_left = 0;
  logic          quad_a = 1'b0;
  logic          quad_b = 1'b0;
  logic [TIME_BITS-1:0] stamp_now = '0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    n_errors++;
  endtask

  // Register write as the block applies it.
  function automatic void apply_reg_write(input cfg_idx_e idx,
                                          input logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      CFG_GAIN_P:     kp = data;
      CFG_GAIN_I:     ki = data;
      CFG_GAIN_D:     kd = data;
      CFG_TARGET_RPM: rpm_goal = data[RPM_BITS-1:0];
      CFG_DUTY_LIMIT: duty_cap = data[DUTY_BITS-1:0];
      CFG_REVERSE:    swap_lines = data[0];
      CFG_CPR:        counts_rev = data[CPR_BITS-1:0];
      default: ;
    endcase
  endfunction

  // Advances the predicted state by one item and returns the result it gives.
  function automatic drive_result_t predict_drive_result(input op_e op, input logic lvl_a,
                                                         input logic lvl_b,
                                                         input logic [TIME_BITS-1:0] stamp);
    drive_result_t res;
    logic [TIME_BITS-1:0] interval;
    longint unsigned rate;
    int err;
    int delta;
    int acc;
    longint power;
    longint mag;
    case (op)
      OP_EDGE_A, OP_EDGE_B: begin
        if (op == OP_EDGE_A) begin
          pos_count = (lvl_a != lvl_b) ? pos_count + 1 : pos_count - 1;
        end
        stamp_prev   = stamp_latest;
        stamp_latest = stamp;
      end
      OP_UPDATE: begin
        // Speed from the last edge interval; a zero interval reads as full speed.
        interval = stamp_latest - stamp_prev;
        if (interval == 0) begin
          speed_held = SPEED_MAX;
        end else begin
          rate = 64'd60000000 / {32'd0, interval};
          rate = rate / ((counts_rev == 0) ? 64'd1 : {48'd0, counts_rev});
          speed_held = (rate > SPEED_MAX) ? SPEED_MAX : rate[SPEED_BITS-1:0];
        end
        // PID step with the error sum held to its window.
        err      = int'(rpm_goal) - int'(speed_held);
        delta    = err - err_prev;
        err_prev = err;
        acc      = err_acc + err;
        if (acc > SUM_HI) acc = SUM_HI;
        if (acc < SUM_LO) acc = SUM_LO;
        err_acc  = acc;
        power = longint'(kp) * err + longint'(ki) * acc + longint'(kd) * delta;
        // Bridge lines follow the sign; zero power coasts.
        if (power > 0) lines_held = swap_lines ? 2'b10 : 2'b01;
        else if (power < 0) lines_held = swap_lines ? 2'b01 : 2'b10;
        else lines_held = 2'b00;
        mag = (power < 0) ? -power : power;
        duty_held = (mag > longint'(duty_cap)) ? duty_cap : mag[DUTY_BITS-1:0];
      end
      default: ;
    endcase
    res.dir_a    = lines_held[0];
    res.dir_b    = lines_held[1];
    res.duty     = duty_held;
    res.position = pos_count;
    res.speed    = speed_held;
    return res;
  endfunction

  // Watches all three channels at the rising edge.
  always @(posedge clk_i) begin : monitor
    drive_result_t got;
    drive_result_t want;
    if (rst_ni) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        apply_reg_write(cfg_idx_e'(cfg_bus.index), cfg_bus.data);
      end
      if (item_bus.valid && item_bus.ready) begin
        want = predict_drive_result(op_e'(item_bus.operation), item_bus.level_a,
                                    item_bus.level_b, item_bus.time_us);
        if (typed_on) want = typed_want;
        pending_results.push_back(want);
      end
      if (result_bus.valid && result_bus.ready) begin
        got.dir_a    = result_bus.dir_a;
        got.dir_b    = result_bus.dir_b;
        got.duty     = result_bus.pwm_duty;
        got.position = result_bus.position;
        got.speed    = result_bus.speed_rpm;
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with no item waiting");
        end else begin
          want = pending_results.pop_front();
          if (got.dir_a !== want.dir_a)
            report_mismatch($sformatf("dir_a got %b want %b", got.dir_a, want.dir_a));
          if (got.dir_b !== want.dir_b)
            report_mismatch($sformatf("dir_b got %b want %b", got.dir_b, want.dir_b));
          if (got.duty !== want.duty)
            report_mismatch($sformatf("pwm_duty got %0d want %0d", got.duty, want.duty));
          if (got.position !== want.position)
            report_mismatch($sformatf("position got %0d want %0d",
                                      got.position, want.position));
          if (got.speed !== want.speed)
            report_mismatch($sformatf("speed_rpm got %0d want %0d", got.speed, want.speed));
        end
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      result_bus.ready = 1'b0;
      hold_left--;
    end else begin
      result_bus.ready = !(receiver_stalls && ($urandom_range(99) < IDLE_PCT));
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offers one item beat and returns at the falling edge after it is taken.
  task automatic send_item(input op_e op, input logic lvl_a, input logic lvl_b,
                           input logic [TIME_BITS-1:0] stamp);
    while (sender_gaps && ($urandom_range(99) < IDLE_PCT)) begin
      item_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    item_bus.valid     = 1'b1;
    item_bus.operation = op;
    item_bus.level_a   = lvl_a;
    item_bus.level_b   = lvl_b;
    item_bus.time_us   = stamp;
    do @(posedge clk_i); while (!item_bus.ready);
    @(negedge clk_i);
    item_bus.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_BITS-1:0] data);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
  endtask

  function automatic stim_row_t reg_row(input cfg_idx_e idx,
                                        input logic [CFG_DATA_BITS-1:0] data);
    stim_row_t row;
    row           = '{reg_idx: CFG_GAIN_P, op: OP_EDGE_A, default: '0};
    row.is_reg    = 1'b1;
    row.reg_idx   = idx;
    row.reg_data  = data;
    return row;
  endfunction

  function automatic stim_row_t item_row(input op_e op, input logic lvl_a, input logic lvl_b,
                                         input logic [TIME_BITS-1:0] stamp);
    stim_row_t row;
    row        = '{reg_idx: CFG_GAIN_P, op: OP_EDGE_A, default: '0};
    row.op     = op;
    row.lvl_a  = lvl_a;
    row.lvl_b  = lvl_b;
    row.stamp  = stamp;
    return row;
  endfunction

  // Item row whose result is known by inspection.
  function automatic stim_row_t known_row(input op_e op, input logic lvl_a, input logic lvl_b,
                                          input logic [TIME_BITS-1:0] stamp,
                                          input logic [1:0] lines, input int pos,
                                          input int speed);
    stim_row_t row;
    row                = item_row(op, lvl_a, lvl_b, stamp);
    row.has_typed      = 1'b1;
    row.typed.dir_a    = lines[0];
    row.typed.dir_b    = lines[1];
    row.typed.duty     = '0;
    row.typed.position = pos;
    row.typed.speed    = SPEED_BITS'(speed);
    return row;
  endfunction

  function automatic logic [CFG_DATA_BITS-1:0] rand_gain();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return CFG_DATA_BITS'($urandom_range(16) - 8);
    else if (pick < 80) return CFG_DATA_BITS'($urandom_range(400) - 200);
    else return CFG_DATA_BITS'($urandom());
  endfunction

  // Writes every register: all high, all low, or a random mix.
  task automatic write_phase_regs(input int mode);
    logic [CFG_DATA_BITS-1:0] vals [N_REGS];
    int pick;
    case (mode)
      0: vals = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd1023, 16'd255, 16'd1, 16'hFFFF};
      1: vals = '{16'h8000, 16'h8000, 16'h8000, 16'd0, 16'd0, 16'd0, 16'd0};
      default: begin
        vals[0] = rand_gain();
        vals[1] = rand_gain();
        vals[2] = rand_gain();
        vals[3] = CFG_DATA_BITS'($urandom_range(1023));
        pick    = $urandom_range(99);
        vals[4] = (pick < 15) ? 16'd255 : (pick < 25) ? 16'd0
                : CFG_DATA_BITS'($urandom_range(255));
        vals[5] = CFG_DATA_BITS'($urandom_range(1));
        pick    = $urandom_range(99);
        vals[6] = (pick < 60) ? CFG_DATA_BITS'($urandom_range(8, 1)) : (pick < 75) ? 16'd0
                : (pick < 85) ? 16'hFFFF : CFG_DATA_BITS'($urandom());
      end
    endcase
    wait_drained();
    for (int i = 0; i < N_REGS; i++) write_reg(cfg_idx_e'(i), vals[i]);
  endtask

  // Mostly clean quadrature bursts closed by a control update, some noise beats.
  task automatic run_random_phase(input int n_items, input logic with_hold);
    int sent;
    int edges;
    int pick;
    logic fwd;
    logic toggle_a;
    logic hold_sent;
    logic [TIME_BITS-1:0] gap;
    sent      = 0;
    hold_sent = 1'b0;
    while (sent < n_items) begin
      if (with_hold && !hold_sent && sent >= 10) begin
        hold_req  = 1'b1;
        hold_sent = 1'b1;
      end
      if ($urandom_range(99) < 15) begin
        send_item(op_e'($urandom_range(3)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  $urandom());
        sent++;
      end else begin
        fwd   = 1'($urandom_range(1));
        edges = $urandom_range(6, 1);
        repeat (edges) begin
          toggle_a = fwd ? (quad_a == quad_b) : (quad_a != quad_b);
          if (toggle_a) quad_a = ~quad_a;
          else quad_b = ~quad_b;
          // Edge spacing spans zero, clamped, mid-range and wrapping intervals.
          pick = $urandom_range(99);
          if (pick < 10) gap = '0;
          else if (pick < 35) gap = $urandom_range(120000, 1);
          else if (pick < 75) gap = $urandom_range(1500000, 100000);
          else if (pick < 90) gap = $urandom_range(60000000, 1500000);
          else gap = $urandom();
          stamp_now += gap;
          send_item(toggle_a ? OP_EDGE_A : OP_EDGE_B, quad_a, quad_b, stamp_now);
          sent++;
        end
        send_item(OP_UPDATE, 1'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
        sent++;
      end
    end
  endtask

  // Main sequence.
  initial begin
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = '0;
    cfg_bus.data       = '0;
    item_bus.valid     = 1'b0;
    item_bus.operation = '0;
    item_bus.level_a   = 1'b0;
    item_bus.level_b   = 1'b0;
    item_bus.time_us   = '0;
    result_bus.ready   = 1'b0;
    rst_ni             = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows: reset state, ignored op, zero interval, position
    // counting both ways, timestamp wrap, register extremes, polarity swap.
    directed_rows.push_back(known_row(OP_NONE, 1'b1, 1'b1, 32'hFFFF_FFFF, 2'b00, 0, 0));
    directed_rows.push_back(known_row(OP_UPDATE, 1'b0, 1'b0, 32'd0, 2'b00, 0, 500));
    directed_rows.push_back(known_row(OP_EDGE_A, 1'b1, 1'b0, 32'd0, 2'b00, 1, 500));
    directed_rows.push_back(known_row(OP_EDGE_A, 1'b0, 1'b1, 32'd100, 2'b00, 2, 500));
    directed_rows.push_back(known_row(OP_EDGE_A, 1'b1, 1'b1, 32'd200, 2'b00, 1, 500));
    directed_rows.push_back(known_row(OP_EDGE_A, 1'b0, 1'b0, 32'hFFFF_FFFF, 2'b00, 0, 500));
    directed_rows.push_back(known_row(OP_EDGE_B, 1'b1, 1'b1, 32'd16, 2'b00, 0, 500));
    directed_rows.push_back(item_row(OP_UPDATE, 1'b0, 1'b0, 32'd0));
    directed_rows.push_back(reg_row(CFG_GAIN_P, 16'h8000));
    directed_rows.push_back(reg_row(CFG_GAIN_I, 16'h7FFF));
    directed_rows.push_back(reg_row(CFG_GAIN_D, 16'h8000));
    directed_rows.push_back(reg_row(CFG_TARGET_RPM, 16'd1023));
    directed_rows.push_back(reg_row(CFG_DUTY_LIMIT, 16'd0));
    directed_rows.push_back(reg_row(CFG_REVERSE, 16'd1));
    directed_rows.push_back(reg_row(CFG_CPR, 16'd0));
    directed_rows.push_back(item_row(OP_EDGE_B, 1'b0, 1'b0, 32'd1000010));
    directed_rows.push_back(item_row(OP_UPDATE, 1'b1, 1'b1, 32'd0));
    directed_rows.push_back(item_row(OP_NONE, 1'b0, 1'b0, 32'd0));
    directed_rows.push_back(reg_row(CFG_DUTY_LIMIT, 16'd255));
    directed_rows.push_back(reg_row(CFG_GAIN_D, 16'h7FFF));
    directed_rows.push_back(reg_row(CFG_GAIN_I, 16'h8000));
    directed_rows.push_back(reg_row(CFG_CPR, 16'hFFFF));
    directed_rows.push_back(reg_row(CFG_TARGET_RPM, 16'd0));
    directed_rows.push_back(item_row(OP_EDGE_A, 1'b0, 1'b0, 32'd2000000));
    directed_rows.push_back(item_row(OP_EDGE_A, 1'b1, 1'b1, 32'd2000000));
    directed_rows.push_back(item_row(OP_UPDATE, 1'b0, 1'b0, 32'd0));
    directed_rows.push_back(item_row(OP_EDGE_B, 1'b0, 1'b1, 32'hFFFF_FFFF));
    directed_rows.push_back(item_row(OP_UPDATE, 1'b0, 1'b0, 32'hFFFF_FFFF));
    directed_rows.push_back(reg_row(CFG_REVERSE, 16'd0));
    directed_rows.push_back(reg_row(CFG_GAIN_P, 16'd1));
    directed_rows.push_back(reg_row(CFG_GAIN_I, 16'd0));
    directed_rows.push_back(reg_row(CFG_GAIN_D, 16'd0));
    directed_rows.push_back(reg_row(CFG_TARGET_RPM, 16'd300));
    directed_rows.push_back(reg_row(CFG_CPR, 16'd4));
    directed_rows.push_back(item_row(OP_EDGE_A, 1'b1, 1'b0, 32'd49999));
    directed_rows.push_back(item_row(OP_UPDATE, 1'b0, 1'b0, 32'd0));
    directed_rows.push_back(item_row(OP_EDGE_A, 1'b0, 1'b0, 32'd149999));
    directed_rows.push_back(item_row(OP_UPDATE, 1'b0, 1'b0, 32'd0));
    directed_rows.push_back(reg_row(CFG_REVERSE, 16'd1));
    directed_rows.push_back(item_row(OP_UPDATE, 1'b1, 1'b0, 32'd0));

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_reg) begin
        wait_drained();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        typed_on   = directed_rows[i].has_typed;
        typed_want = directed_rows[i].typed;
        send_item(directed_rows[i].op, directed_rows[i].lvl_a, directed_rows[i].lvl_b,
                  directed_rows[i].stamp);
        typed_on   = 1'b0;
      end
    end

    // Random phases, each under fresh register settings; one runs with no idling.
    for (int p = 0; p < PHASES; p++) begin
      sender_gaps     = (p != QUIET_PHASE);
      receiver_stalls = (p != QUIET_PHASE);
      write_phase_regs(p);
      run_random_phase(ITEMS_PER_PHASE, p == HOLD_PHASE);
    end

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
